// ===== hw/rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status types for the quadtree region splitter.
// No dependencies; used by the input and output interfaces, controller, datapath and top level.
package qrs_pkg;
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 64;
  localparam int STACK_DEPTH   = 19;
  localparam int RESET_CHANNEL = 48;
  localparam int CHAN_MAX      = 255;
  localparam int CHILDREN      = 4;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 7;
  localparam int LVL_W  = 3;
  localparam int ADDR_W = X_W + Y_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = 8 + ADDR_W;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int SI_W   = $clog2(STACK_DEPTH);
  localparam int DIV_W  = 3;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [1:0] REG_MIN_SIZE     = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [LVL_W-1:0]  level;
  } region_t;

  typedef struct packed {
    logic clear_step;
    logic write_pixel;
    logic start_walk;
    logic pop;
    logic split;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_root;
    logic scan_done;
    logic leaf;
    logic div_last;
    logic out_free;
  } stat_t;
endpackage

// ===== hw/rtl/qrs_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: pixel write or fetch command with valid/ready handshake.
// Depends on qrs_pkg.
interface qrs_in_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [qrs_pkg::X_W-1:0] pixel_x;
  logic [qrs_pkg::Y_W-1:0] pixel_y;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  modport source (output valid, command, pixel_x, pixel_y, red, green, blue, input ready);
  modport sink (input valid, command, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

// ===== hw/rtl/qrs_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: one leaf region per fetch, valid/ready handshake.
// Depends on qrs_pkg.
interface qrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [qrs_pkg::X_W-1:0]    region_x;
  logic [qrs_pkg::Y_W-1:0]    region_y;
  logic [qrs_pkg::SIZE_W-1:0] region_width;
  logic [qrs_pkg::SIZE_W-1:0] region_height;
  logic [7:0]                 mean_red;
  logic [7:0]                 mean_green;
  logic [7:0]                 mean_blue;
  logic [7:0]                 spread;
  logic [qrs_pkg::LVL_W-1:0]  tree_level;
  logic                       last_region;
  modport source (output valid, region_x, region_y, region_width, region_height, mean_red,
                  mean_green, mean_blue, spread, tree_level, last_region, input ready);
  modport sink (input valid, region_x, region_y, region_width, region_height, mean_red,
                mean_green, mean_blue, spread, tree_level, last_region, output ready);
endinterface

// ===== hw/rtl/qrs_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and data with valid/ready.
// No dependencies.
interface qrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/qrs_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences clear, scan, split, divide and emit.
// Depends on qrs_pkg.
module qrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_command,
  output logic           in_ready,
  input  qrs_pkg::stat_t stat,
  output qrs_pkg::cmd_t  cmd
);
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state, state_next;
  logic       acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc && in_command == qrs_pkg::CMD_WRITE) cmd.write_pixel = 1'b1;
        if (acc && in_command == qrs_pkg::CMD_FETCH) begin
          cmd.start_walk = stat.need_root;
          state_next     = S_POP;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.leaf) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.split  = 1'b1;
          state_next = S_POP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end
endmodule

// ===== hw/rtl/qrs_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: pixel memory, region stack, scan accumulators, divider, output register.
// Depends on qrs_pkg and qrs_out_if.
module qrs_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  qrs_pkg::cmd_t           cmd,
  output qrs_pkg::stat_t          stat,
  input  logic [qrs_pkg::X_W-1:0] pixel_x,
  input  logic [qrs_pkg::Y_W-1:0] pixel_y,
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  qrs_out_if.source               out_ch
);
  logic [23:0] mem [qrs_pkg::DEPTH];
  logic [23:0] mem_q;
  logic [qrs_pkg::ADDR_W-1:0] clr_addr, raddr, waddr;
  logic [23:0] wdata;
  logic        we;

  logic [6:0] image_width, image_height, min_size;
  logic [7:0] spread_threshold;
  logic [6:0] ew, eh;

  qrs_pkg::region_t stack [qrs_pkg::STACK_DEPTH];
  logic [qrs_pkg::SP_W-1:0] count;
  logic                     walk_active;
  qrs_pkg::region_t         cur;

  logic [qrs_pkg::X_W-1:0] cx;
  logic [qrs_pkg::Y_W-1:0] cy;
  logic scan_run, rd_v, rd_last, is_last;
  logic [qrs_pkg::SUM_W-1:0] sum [3];
  logic [qrs_pkg::SUM_W-1:0] rem [3];
  logic [7:0] lo [3];
  logic [7:0] hi [3];
  logic [7:0] q [3];
  logic [qrs_pkg::CNT_W-1:0] npix;
  logic [qrs_pkg::DIV_W-1:0] k;
  logic [qrs_pkg::SUM_W-1:0] dsub;
  logic [7:0] rng [3];
  logic [7:0] spread_v;
  logic [qrs_pkg::SP_W:0] room;
  logic [6:0] lw, th;

  assign ew = (image_width == 7'd0) ? 7'd1 :
              (image_width > 7'(qrs_pkg::MAX_WIDTH)) ? 7'(qrs_pkg::MAX_WIDTH) : image_width;
  assign eh = (image_height == 7'd0) ? 7'd1 :
              (image_height > 7'(qrs_pkg::MAX_HEIGHT)) ? 7'(qrs_pkg::MAX_HEIGHT) : image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 7'(qrs_pkg::MAX_WIDTH);
      image_height     <= 7'(qrs_pkg::MAX_HEIGHT);
      spread_threshold <= 8'd20;
      min_size         <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        qrs_pkg::REG_IMAGE_WIDTH:  image_width      <= cfg_data[6:0];
        qrs_pkg::REG_IMAGE_HEIGHT: image_height     <= cfg_data[6:0];
        qrs_pkg::REG_THRESHOLD:    spread_threshold <= cfg_data;
        qrs_pkg::REG_MIN_SIZE:     min_size         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // pixel memory: one write port for clear and pixel writes, one registered read port
  assign we    = cmd.clear_step ||
                 (cmd.write_pixel && ({1'b0, pixel_x} < ew) && ({1'b0, pixel_y} < eh));
  assign waddr = cmd.clear_step ? clr_addr : {pixel_y, pixel_x};
  assign wdata = cmd.clear_step ? {3{8'(qrs_pkg::RESET_CHANNEL)}} : {red, green, blue};
  assign raddr = {qrs_pkg::Y_W'(cur.y + cy), qrs_pkg::X_W'(cur.x + cx)};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
  end

  // region stack and walk state
  assign lw   = cur.w >> 1;
  assign th   = cur.h >> 1;
  assign room = (qrs_pkg::SP_W + 1)'(count) + (qrs_pkg::SP_W + 1)'(qrs_pkg::CHILDREN);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      walk_active <= 1'b0;
    end else begin
      if (cmd.start_walk) begin
        stack[0]    <= '{x: '0, y: '0, w: ew, h: eh, level: '0};
        count       <= qrs_pkg::SP_W'(1);
        walk_active <= 1'b1;
      end
      if (cmd.pop) begin
        cur   <= stack[qrs_pkg::SI_W'(count - 1'b1)];
        count <= count - 1'b1;
      end
      if (cmd.split) begin
        stack[qrs_pkg::SI_W'(count)] <= '{x: qrs_pkg::X_W'(cur.x + lw),
            y: qrs_pkg::Y_W'(cur.y + th), w: cur.w - lw, h: cur.h - th, level: cur.level + 1'b1};
        stack[qrs_pkg::SI_W'(count + 1'b1)] <= '{x: cur.x,
            y: qrs_pkg::Y_W'(cur.y + th), w: lw, h: cur.h - th, level: cur.level + 1'b1};
        stack[qrs_pkg::SI_W'(count + 2'd2)] <= '{x: qrs_pkg::X_W'(cur.x + lw),
            y: cur.y, w: cur.w - lw, h: th, level: cur.level + 1'b1};
        stack[qrs_pkg::SI_W'(count + 2'd3)] <= '{x: cur.x, y: cur.y, w: lw, h: th,
            level: cur.level + 1'b1};
        count <= qrs_pkg::SP_W'(room);
      end
      if (cmd.emit && count == '0) walk_active <= 1'b0;
    end
  end

  // scan: one address a cycle, accumulate on the registered read data
  assign is_last = ({1'b0, cx} == cur.w - 7'd1) && ({1'b0, cy} == cur.h - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      rd_v     <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_v    <= scan_run;
      rd_last <= scan_run && is_last;
      if (cmd.pop) scan_run <= 1'b1;
      else if (scan_run && is_last) scan_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      cx <= '0;
      cy <= '0;
    end else if (scan_run) begin
      if ({1'b0, cx} == cur.w - 7'd1) begin
        cx <= '0;
        cy <= cy + 1'b1;
      end else begin
        cx <= cx + 1'b1;
      end
    end
  end

  assign dsub = qrs_pkg::SUM_W'(npix) << k;

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      npix <= '0;
      for (int c = 0; c < 3; c++) begin
        sum[c] <= '0;
        lo[c]  <= 8'(qrs_pkg::CHAN_MAX);
        hi[c]  <= '0;
      end
    end else if (rd_v) begin
      npix <= npix + 1'b1;
      for (int c = 0; c < 3; c++) begin
        sum[c] <= sum[c] + qrs_pkg::SUM_W'(mem_q[23-8*c -: 8]);
        if (mem_q[23-8*c -: 8] < lo[c]) lo[c] <= mem_q[23-8*c -: 8];
        if (mem_q[23-8*c -: 8] > hi[c]) hi[c] <= mem_q[23-8*c -: 8];
      end
    end
    if (cmd.div_start) begin
      k <= qrs_pkg::DIV_W'(7);
      for (int c = 0; c < 3; c++) begin
        rem[c] <= sum[c];
        q[c]   <= '0;
      end
    end else if (cmd.div_step) begin
      k <= k - 1'b1;
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsub) begin
          rem[c]  <= rem[c] - dsub;
          q[c][k] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    spread_v = '0;
    for (int c = 0; c < 3; c++) begin
      rng[c] = hi[c] - lo[c];
      if (rng[c] > spread_v) spread_v = rng[c];
    end
  end

  assign stat.clear_last = (clr_addr == {qrs_pkg::ADDR_W{1'b1}});
  assign stat.need_root  = !walk_active || count == '0;
  assign stat.scan_done  = rd_v && rd_last;
  assign stat.leaf       = cur.w <= min_size || cur.h <= min_size ||
                           spread_v <= spread_threshold || cur.w <= 7'd1 || cur.h <= 7'd1 ||
                           room > (qrs_pkg::SP_W + 1)'(qrs_pkg::STACK_DEPTH);
  assign stat.div_last   = (k == '0);
  assign stat.out_free   = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (cmd.emit) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.region_x      <= cur.x;
      out_ch.region_y      <= cur.y;
      out_ch.region_width  <= cur.w;
      out_ch.region_height <= cur.h;
      out_ch.mean_red      <= q[0];
      out_ch.mean_green    <= q[1];
      out_ch.mean_blue     <= q[2];
      out_ch.spread        <= spread_v;
      out_ch.tree_level    <= cur.level;
      out_ch.last_region   <= (count == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qrs_pkg::SP_W'(qrs_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten while stalled");
  a_scan_stop: assert property (@(posedge clk) disable iff (rst)
    stat.scan_done |-> !scan_run)
    else $error("scan still issuing after last pixel");
endmodule

// ===== hw/rtl/quadtree_region_splitter_core.sv =====
`timescale 1ns / 1ps
// Top level of the quadtree region splitter: controller plus datapath.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_cfg_if, qrs_ctrl, qrs_datapath.
//
// Usage:
//   in_ch carries transactions: command 0 writes one RGB pixel (ignored outside the
//   configured image), command 1 fetches the next leaf of a depth-first quadtree walk.
//   out_ch returns one leaf per fetch; writes return nothing. cfg writes the four
//   registers (index 0..3) and is always ready.
// Operation:
//   A pixel write is stored when it is accepted. A fetch pops regions until a leaf is
//   found; each popped region is scanned one pixel per cycle through the pixel memory
//   read port, and a leaf then runs the mean division and the emit step. in_ch is not
//   ready again until that leaf is emitted.
// Reset:
//   After rst the block clears the 4096-entry pixel memory to 48 per channel, one
//   entry a cycle; in_ch is not ready until the clear is done.
// Stall:
//   The result sits in an output register; pixel writes are still accepted while it
//   waits, and a following fetch holds before emitting until the register is free.
module quadtree_region_splitter_core (
  input logic       clk,
  input logic       rst,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch,
  qrs_cfg_if.sink   cfg
);
  qrs_pkg::cmd_t  cmd;
  qrs_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  qrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  qrs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_x   (in_ch.pixel_x),
    .pixel_y   (in_ch.pixel_y),
    .red       (in_ch.red),
    .green     (in_ch.green),
    .blue      (in_ch.blue),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ch    (out_ch)
  );
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for quadtree_region_splitter_core: pixel writes, leaf fetches and register
// writes, with results checked against an in-bench quadtree walk predictor.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_cfg_if and the RTL of the core.
module tb_top;
  typedef struct packed {
    logic [qrs_pkg::X_W-1:0]    x;
    logic [qrs_pkg::Y_W-1:0]    y;
    logic [qrs_pkg::SIZE_W-1:0] w;
    logic [qrs_pkg::SIZE_W-1:0] h;
    logic [7:0]                 mr;
    logic [7:0]                 mg;
    logic [7:0]                 mb;
    logic [7:0]                 spread;
    logic [qrs_pkg::LVL_W-1:0]  level;
    logic                       last;
  } leaf_t;

  class leaf_scoreboard;
    logic [7:0]       img_r[qrs_pkg::DEPTH];
    logic [7:0]       img_g[qrs_pkg::DEPTH];
    logic [7:0]       img_b[qrs_pkg::DEPTH];
    qrs_pkg::region_t pend[qrs_pkg::STACK_DEPTH];
    int               pend_cnt;
    bit               walk_on;
    int               cols, rows, thresh, min_sz;
    leaf_t            leaf_q[$];
    int               errors;
    int               n_leaves;

    function void reset();
      for (int i = 0; i < qrs_pkg::DEPTH; i++) begin
        img_r[i] = 8'(qrs_pkg::RESET_CHANNEL);
        img_g[i] = 8'(qrs_pkg::RESET_CHANNEL);
        img_b[i] = 8'(qrs_pkg::RESET_CHANNEL);
      end
      pend_cnt = 0;
      walk_on  = 0;
      cols = 64; rows = 64; thresh = 20; min_sz = 2;
      errors = 0;
      n_leaves = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        qrs_pkg::REG_IMAGE_WIDTH:  cols   = data & 8'h7F;
        qrs_pkg::REG_IMAGE_HEIGHT: rows   = data & 8'h7F;
        qrs_pkg::REG_THRESHOLD:    thresh = data;
        qrs_pkg::REG_MIN_SIZE:     min_sz = data & 8'h7F;
        default: ;
      endcase
    endfunction

    function void push(int x, int y, int w, int h, int lv);
      if (pend_cnt < qrs_pkg::STACK_DEPTH) begin
        pend[pend_cnt] = '{x: qrs_pkg::X_W'(x), y: qrs_pkg::Y_W'(y),
                           w: qrs_pkg::SIZE_W'(w), h: qrs_pkg::SIZE_W'(h),
                           level: qrs_pkg::LVL_W'(lv)};
        pend_cnt++;
      end
    endfunction

    function void note_input(logic cmd, int px, int py, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
      int               ew, eh, cnt, best, lw, th;
      int               sum[3], lo[3], hi[3], v[3];
      qrs_pkg::region_t cur;
      bit               is_leaf;
      leaf_t            res;
      ew = (cols < 1) ? 1 : (cols > qrs_pkg::MAX_WIDTH) ? qrs_pkg::MAX_WIDTH : cols;
      eh = (rows < 1) ? 1 : (rows > qrs_pkg::MAX_HEIGHT) ? qrs_pkg::MAX_HEIGHT : rows;
      if (cmd == qrs_pkg::CMD_WRITE) begin
        if (px < ew && py < eh) begin
          img_r[py * qrs_pkg::MAX_WIDTH + px] = r;
          img_g[py * qrs_pkg::MAX_WIDTH + px] = g;
          img_b[py * qrs_pkg::MAX_WIDTH + px] = b;
        end
        return;
      end
      if (!walk_on || pend_cnt == 0) begin
        pend_cnt = 0;
        push(0, 0, ew, eh, 0);
        walk_on = 1;
      end
      forever begin
        pend_cnt--;
        cur = pend[pend_cnt];
        cnt = 0;
        for (int c = 0; c < 3; c++) begin
          sum[c] = 0; lo[c] = 255; hi[c] = 0;
        end
        for (int yy = cur.y; yy < cur.y + cur.h && yy < qrs_pkg::MAX_HEIGHT; yy++) begin
          for (int xx = cur.x; xx < cur.x + cur.w && xx < qrs_pkg::MAX_WIDTH; xx++) begin
            v[0] = img_r[yy * qrs_pkg::MAX_WIDTH + xx];
            v[1] = img_g[yy * qrs_pkg::MAX_WIDTH + xx];
            v[2] = img_b[yy * qrs_pkg::MAX_WIDTH + xx];
            for (int c = 0; c < 3; c++) begin
              sum[c] += v[c];
              if (v[c] < lo[c]) lo[c] = v[c];
              if (v[c] > hi[c]) hi[c] = v[c];
            end
            cnt++;
          end
        end
        best = 0;
        for (int c = 0; c < 3; c++)
          if (cnt > 0 && hi[c] - lo[c] > best) best = hi[c] - lo[c];
        is_leaf = cur.w <= min_sz || cur.h <= min_sz || best <= thresh ||
                  cur.w <= 1 || cur.h <= 1 ||
                  pend_cnt + qrs_pkg::CHILDREN > qrs_pkg::STACK_DEPTH;
        if (is_leaf) begin
          res.x = cur.x; res.y = cur.y; res.w = cur.w; res.h = cur.h;
          res.mr = 8'(cnt ? sum[0] / cnt : 0);
          res.mg = 8'(cnt ? sum[1] / cnt : 0);
          res.mb = 8'(cnt ? sum[2] / cnt : 0);
          res.spread = 8'(best);
          res.level  = cur.level;
          res.last   = (pend_cnt == 0);
          if (pend_cnt == 0) walk_on = 0;
          leaf_q.push_back(res);
          return;
        end
        lw = cur.w / 2;
        th = cur.h / 2;
        push(cur.x + lw, cur.y + th, cur.w - lw, cur.h - th, cur.level + 1);
        push(cur.x,      cur.y + th, lw,         cur.h - th, cur.level + 1);
        push(cur.x + lw, cur.y,      cur.w - lw, th,         cur.level + 1);
        push(cur.x,      cur.y,      lw,         th,         cur.level + 1);
      end
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(leaf_t got);
      leaf_t e;
      if (leaf_q.size() == 0) begin
        $error("unexpected leaf result at x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      e = leaf_q.pop_front();
      n_leaves++;
      cmp("region_x", e.x, got.x);
      cmp("region_y", e.y, got.y);
      cmp("region_width", e.w, got.w);
      cmp("region_height", e.h, got.h);
      cmp("mean_red", e.mr, got.mr);
      cmp("mean_green", e.mg, got.mg);
      cmp("mean_blue", e.mb, got.mb);
      cmp("spread", e.spread, got.spread);
      cmp("tree_level", e.level, got.level);
      cmp("last_region", e.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  qrs_in_if  in_ch ();
  qrs_out_if out_ch ();
  qrs_cfg_if cfg ();

  quadtree_region_splitter_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  leaf_scoreboard sb;
  bit quiet;
  int n_items;
  int n_cfg;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{x: out_ch.region_x, y: out_ch.region_y, w: out_ch.region_width,
                          h: out_ch.region_height, mr: out_ch.mean_red,
                          mg: out_ch.mean_green, mb: out_ch.mean_blue,
                          spread: out_ch.spread, level: out_ch.tree_level,
                          last: out_ch.last_region});
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(logic cmd, logic [5:0] px, logic [5:0] py, logic [7:0] r,
                      logic [7:0] g, logic [7:0] b);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pixel_x <= px;
    in_ch.pixel_y <= py;
    in_ch.red     <= r;
    in_ch.green   <= g;
    in_ch.blue    <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, px, py, r, g, b);
    n_items++;
  endtask

  task automatic fetch();
    send(qrs_pkg::CMD_FETCH, 6'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom));
  endtask

  task automatic put_pixel(int px, int py, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send(qrs_pkg::CMD_WRITE, 6'(px), 6'(py), r, g, b);
  endtask

  task automatic finish_walk();
    do fetch(); while (sb.walk_on);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.leaf_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, data);
    n_cfg++;
  endtask

  task automatic set_all(logic [7:0] w, logic [7:0] h, logic [7:0] thr, logic [7:0] ms);
    drain();
    set_reg(qrs_pkg::REG_IMAGE_WIDTH, w);
    set_reg(qrs_pkg::REG_IMAGE_HEIGHT, h);
    set_reg(qrs_pkg::REG_THRESHOLD, thr);
    set_reg(qrs_pkg::REG_MIN_SIZE, ms);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    int w, h, steps;
    sb = new();
    sb.reset();
    quiet = 0;
    n_items = 0;
    n_cfg = 0;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= qrs_pkg::CMD_WRITE;
    in_ch.pixel_x <= '0;
    in_ch.pixel_y <= '0;
    in_ch.red <= '0;
    in_ch.green <= '0;
    in_ch.blue <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= qrs_pkg::REG_IMAGE_WIDTH;
    cfg.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // uniform reset image: root is one leaf
    fetch();
    // small image, no threshold, extremes of the pixel fields
    set_all(4, 4, 0, 0);
    put_pixel(0, 0, 8'hFF, 8'h00, 8'hFF);
    put_pixel(3, 3, 8'h00, 8'hFF, 8'h00);
    put_pixel(3, 0, 8'hAA, 8'h55, 8'hFF);
    put_pixel(63, 63, 8'h00, 8'h00, 8'h00);
    put_pixel(4, 1, 8'h01, 8'h02, 8'h03);
    put_pixel(1, 4, 8'h01, 8'h02, 8'h03);
    finish_walk();
    // odd sizes, saturated width with zero height, then large threshold and minimum size
    set_all(5, 3, 0, 0);
    finish_walk();
    set_all(8'hFF, 8'h00, 0, 0);
    fetch();
    set_all(8, 8, 8'hFF, 64);
    fetch();
    set_all(6, 6, 0, 64);
    fetch();

    // random phases: configure, paint, walk with writes mixed in
    while (n_items < 140) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) % 20 : $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if (n_items > 115) quiet = 1;
      set_all(8'(w), 8'(h),
              8'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255) % 80),
              8'($urandom_range(0, 3)));
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 4) == 0)
          put_pixel($urandom_range(0, 63), $urandom_range(0, 63),
                    8'($urandom), 8'($urandom), 8'($urandom));
        else
          put_pixel($urandom_range(0, w > 0 ? w - 1 : 0), $urandom_range(0, h - 1),
                    8'($urandom), 8'($urandom), 8'($urandom));
      end
      steps = $urandom_range(3, 16);
      while (steps > 0) begin
        if ($urandom_range(0, 3) == 0)
          put_pixel($urandom_range(0, 63), $urandom_range(0, 63),
                    8'($urandom), 8'($urandom), 8'($urandom));
        else begin
          fetch();
          steps--;
          if ($urandom_range(0, 9) == 0) drain();
        end
      end
    end
    drain();
    while (sb.leaf_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d transactions, %0d leaf results checked, %0d register writes",
             n_items, sb.n_leaves, n_cfg);
    if (sb.errors == 0 && sb.leaf_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_in_if.sv
hw/rtl/qrs_out_if.sv
hw/rtl/qrs_cfg_if.sv
hw/rtl/qrs_ctrl.sv
hw/rtl/qrs_datapath.sv
hw/rtl/quadtree_region_splitter_core.sv
verif/tb_top.sv
